// ===== rtl/string_hash_bucket_index_top_macros.svh =====
// assertion helpers, clocked on aclk and disabled while aresetn is low
`ifndef STRING_HASH_BUCKET_INDEX_TOP_MACROS_SVH
`define STRING_HASH_BUCKET_INDEX_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define SHBI_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define SHBI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SHBI_ASSERT_SAME(label, ante, cons)

`define SHBI_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/shbi_pkg.sv =====
package shbi_pkg;

    localparam int HASH_W   = 64;
    localparam int BYTE_W   = 8;
    localparam int BUCKET_W = 16;
    localparam int CNT_W    = 6;
    localparam int STEP_W   = 2;
    localparam int HASH_SHIFT = 7;

    localparam logic [HASH_W-1:0]   HASH_SEED       = 64'd531;
    localparam logic [BUCKET_W-1:0] NUM_BUCKETS_RST = 16'd50000;
    localparam logic [CNT_W-1:0]    DIV_LAST_CNT    = 6'd63;

    // microprogram addresses
    localparam logic [STEP_W-1:0] STEP_FETCH = 2'd0;
    localparam logic [STEP_W-1:0] STEP_INIT  = 2'd1;
    localparam logic [STEP_W-1:0] STEP_DIV   = 2'd2;
    localparam logic [STEP_W-1:0] STEP_OUT   = 2'd3;

    typedef enum logic [2:0] {
        OP_ACC      = 3'd0,
        OP_DIV_INIT = 3'd1,
        OP_DIV_STEP = 3'd2,
        OP_WRITE    = 3'd3
    } op_t;

    typedef enum logic [1:0] {
        COND_ALWAYS   = 2'd0,
        COND_TERM     = 2'd1,
        COND_CNT_DONE = 2'd2,
        COND_OUT_FREE = 2'd3
    } cond_t;

    typedef struct packed {
        logic              in_ready;
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        logic term_accepted;
        logic cnt_done;
        logic out_free;
    } status_t;

    // control store: on a true condition go to target, otherwise repeat the step
    function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] addr);
        ctrl_word_t w;
        unique case (addr)
            STEP_FETCH: w = '{in_ready: 1'b1, op: OP_ACC,      cond: COND_TERM,
                              target: STEP_INIT};
            STEP_INIT:  w = '{in_ready: 1'b0, op: OP_DIV_INIT, cond: COND_ALWAYS,
                              target: STEP_DIV};
            STEP_DIV:   w = '{in_ready: 1'b0, op: OP_DIV_STEP, cond: COND_CNT_DONE,
                              target: STEP_OUT};
            STEP_OUT:   w = '{in_ready: 1'b0, op: OP_WRITE,    cond: COND_OUT_FREE,
                              target: STEP_FETCH};
            default:    w = '{in_ready: 1'b0, op: OP_ACC,      cond: COND_ALWAYS,
                              target: STEP_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/shbi_sequencer.sv =====
`include "string_hash_bucket_index_top_macros.svh"

module shbi_sequencer
    import shbi_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  status_t    status,
    output ctrl_word_t ctrl
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              cond_true;

    assign ctrl = ucode_rom(step_reg);

    always_comb begin
        case (ctrl.cond)
            COND_ALWAYS:   cond_true = 1'b1;
            COND_TERM:     cond_true = status.term_accepted;
            COND_CNT_DONE: cond_true = status.cnt_done;
            COND_OUT_FREE: cond_true = status.out_free;
            default:       cond_true = 1'b0;
        endcase
        step_next = cond_true ? ctrl.target : step_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_FETCH;
        end else begin
            step_reg <= step_next;
        end
    end

    `SHBI_ASSERT_NEXT(a_div_exit, step_reg == STEP_DIV && status.cnt_done, step_reg == STEP_OUT)
    `SHBI_ASSERT_NEXT(a_term_start, step_reg == STEP_FETCH && status.term_accepted,
                      step_reg == STEP_INIT)
    `SHBI_ASSERT_SAME(a_ready_fetch_only, ctrl.in_ready, step_reg == STEP_FETCH)

endmodule

// ===== rtl/shbi_datapath.sv =====
`include "string_hash_bucket_index_top_macros.svh"

module shbi_datapath
    import shbi_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  ctrl_word_t          ctrl,
    input  logic                cfg_wr_en,
    input  logic [BUCKET_W-1:0] cfg_wr_data,
    input  logic                s_valid,
    input  logic [BYTE_W-1:0]   s_key_byte,
    output status_t             status,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [BUCKET_W-1:0] m_bucket_index
);

    logic [BUCKET_W-1:0] num_buckets_reg;
    logic [HASH_W-1:0]   hash_reg;
    logic [HASH_W-1:0]   quot_reg;
    logic [BUCKET_W-1:0] rem_reg;
    logic [BUCKET_W-1:0] div_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                m_valid_reg;
    logic [BUCKET_W-1:0] m_bucket_index_reg;

    logic                accepted;
    logic                byte_zero;
    logic                out_free;
    logic [HASH_W-1:0]   hash_mac;
    logic [BUCKET_W:0]   rem_shift;
    logic [BUCKET_W:0]   rem_diff;
    logic [BUCKET_W-1:0] rem_next;

    assign accepted  = ctrl.in_ready && s_valid;
    assign byte_zero = (s_key_byte == '0);
    assign out_free  = !m_valid_reg || m_ready;

    // hash*129 + byte, wrapping
    assign hash_mac = (hash_reg << HASH_SHIFT) + hash_reg
                      + {{(HASH_W-BYTE_W){1'b0}}, s_key_byte};

    // one restoring division step, msb of the dividend first
    assign rem_shift = {rem_reg, quot_reg[HASH_W-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign rem_next  = (rem_shift >= {1'b0, div_reg}) ? rem_diff[BUCKET_W-1:0]
                                                      : rem_shift[BUCKET_W-1:0];

    assign status.term_accepted = accepted && byte_zero;
    assign status.cnt_done      = (cnt_reg == '0);
    assign status.out_free      = out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_buckets_reg <= NUM_BUCKETS_RST;
        end else if (cfg_wr_en) begin
            num_buckets_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= HASH_SEED;
        end else if (ctrl.op == OP_ACC && accepted && !byte_zero) begin
            hash_reg <= hash_mac;
        end else if (ctrl.op == OP_DIV_INIT) begin
            hash_reg <= HASH_SEED;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            case (ctrl.op)
                OP_DIV_INIT: cnt_reg <= DIV_LAST_CNT;
                OP_DIV_STEP: cnt_reg <= cnt_reg - 1'b1;
                default:     cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (ctrl.op)
            OP_DIV_INIT: begin
                quot_reg <= hash_reg;
                rem_reg  <= '0;
                div_reg  <= num_buckets_reg;
            end
            OP_DIV_STEP: begin
                quot_reg <= {quot_reg[HASH_W-2:0], 1'b0};
                rem_reg  <= rem_next;
            end
            default: begin
                quot_reg <= quot_reg;
                rem_reg  <= rem_reg;
            end
        endcase
    end

    // output register holds the transaction until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.op == OP_WRITE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.op == OP_WRITE && out_free) begin
            m_bucket_index_reg <= (div_reg == '0) ? '0 : rem_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_bucket_index = m_bucket_index_reg;

    `SHBI_ASSERT_NEXT(a_seed_reload, ctrl.op == OP_DIV_INIT, hash_reg == HASH_SEED)
    `SHBI_ASSERT_SAME(a_rem_bound, ctrl.op == OP_DIV_STEP && div_reg != '0, rem_reg < div_reg)
    `SHBI_ASSERT_NEXT(a_out_loaded, ctrl.op == OP_WRITE && out_free, m_valid_reg)

endmodule

// ===== rtl/string_hash_bucket_index_top.sv =====
// Byte-serial string hash to bucket index. Each nonzero key byte is folded into
// a 64-bit hash (hash*129 + byte, seed 531) in the cycle it is accepted, so key
// bytes stream at one per cycle while s_ready is high. A zero byte ends the key:
// it is accepted, and the block then runs a setup step, a bit-serial restoring
// divider over the 64 dividend bits (one dividend bit per cycle), and a step that
// loads the output register once it is free. s_ready is low from the cycle
// after the terminator until the result is loaded; the result register then
// holds the transaction while the next key streams in. A bucket count of 0
// yields index 0. num_buckets resets to 50000.
module string_hash_bucket_index_top
    import shbi_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [BUCKET_W-1:0] cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [BYTE_W-1:0]   s_key_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [BUCKET_W-1:0] m_bucket_index
);

    ctrl_word_t ctrl;
    status_t    status;

    shbi_sequencer u_sequencer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    shbi_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_key_byte     (s_key_byte),
        .status         (status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bucket_index (m_bucket_index)
    );

    assign s_ready = ctrl.in_ready;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import shbi_pkg::*;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 11;
    localparam int IDLE_PCT         = 24;
    localparam int DRAIN_CYCLES     = 100;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int HOLD_CYCLES      = 300;
    localparam int HOLD_AFTER       = 20;
    localparam int HOLD_MIN_PENDING = 30;
    localparam int REPORT_MAX       = 10;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [BUCKET_W-1:0] cfg_wr_data = '0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic [BYTE_W-1:0]   s_key_byte  = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic [BUCKET_W-1:0] m_bucket_index;

    logic [BYTE_W-1:0]   key_bytes_pending[$];
    logic [BUCKET_W-1:0] bucket_expect[$];
    logic [HASH_W-1:0]   key_hash     = HASH_SEED;
    logic [BUCKET_W-1:0] bucket_count = NUM_BUCKETS_RST;
    bit                  calm         = 1'b0;
    bit                  hold_done    = 1'b0;
    int                  hold_left    = 0;
    int                  mismatches   = 0;
    int                  results_seen = 0;
    int                  quiet_cycles = 0;

    string_hash_bucket_index_top uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_key_byte     (s_key_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bucket_index (m_bucket_index)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    function automatic logic [HASH_W-1:0] fold_byte(input logic [HASH_W-1:0] h,
                                                    input logic [BYTE_W-1:0] b);
        return (h << HASH_SHIFT) + h + HASH_W'(b);
    endfunction

    function automatic logic [BUCKET_W-1:0] bucket_of(input logic [HASH_W-1:0] h,
                                                      input logic [BUCKET_W-1:0] n);
        if (n == '0) begin
            return '0;
        end
        return BUCKET_W'(h % HASH_W'(n));
    endfunction

    // key byte driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (key_bytes_pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                s_valid    <= 1'b1;
                s_key_byte <= key_bytes_pending.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off so the block backs up
    // starts only while plenty of key bytes are still queued
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER
                     && key_bytes_pending.size() >= HOLD_MIN_PENDING) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // monitor: predicts on accepted key bytes, checks accepted results
    always @(posedge aclk) begin : monitor
        logic [BUCKET_W-1:0] want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (s_key_byte != '0) begin
                    key_hash = fold_byte(key_hash, s_key_byte);
                end else begin
                    bucket_expect.push_back(bucket_of(key_hash, bucket_count));
                    key_hash = HASH_SEED;
                end
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (bucket_expect.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("unexpected result transaction: bucket_index %0d",
                                 m_bucket_index);
                    end
                end else begin
                    want = bucket_expect.pop_front();
                    if (m_bucket_index !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX) begin
                            $display("bucket_index mismatch: expected %0d, got %0d",
                                     want, m_bucket_index);
                        end
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", quiet_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    task automatic write_buckets(input logic [BUCKET_W-1:0] n);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n;
        bucket_count = n;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_key(input int len, input bit terminate);
        repeat (len) key_bytes_pending.push_back(BYTE_W'($urandom_range(255, 1)));
        if (terminate) begin
            key_bytes_pending.push_back('0);
        end
    endtask

    // mostly short keys so results stay frequent, a few long ones to wrap the hash
    task automatic push_random_keys(input int count);
        int added;
        int len;
        int r;
        added = 0;
        while (added < count) begin
            r = $urandom_range(99);
            if (r < 80) begin
                len = $urandom_range(8, 0);
            end else if (r < 95) begin
                len = $urandom_range(20, 9);
            end else begin
                len = $urandom_range(60, 30);
            end
            push_key(len, 1'b1);
            added += len + 1;
        end
    endtask

    task automatic wait_idle();
        do begin
            @(posedge aclk);
        end while (key_bytes_pending.size() != 0 || s_valid || bucket_expect.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty key, byte extremes, alternating bits, a key that wraps the hash
        key_bytes_pending.push_back(8'h00);
        key_bytes_pending.push_back(8'hff);
        key_bytes_pending.push_back(8'h00);
        key_bytes_pending.push_back(8'h01);
        key_bytes_pending.push_back(8'h00);
        key_bytes_pending.push_back(8'h80);
        key_bytes_pending.push_back(8'h7f);
        key_bytes_pending.push_back(8'haa);
        key_bytes_pending.push_back(8'h55);
        key_bytes_pending.push_back(8'h00);
        repeat (12) key_bytes_pending.push_back(8'hff);
        key_bytes_pending.push_back(8'h00);
        wait_idle();

        // zero bucket count gives index 0
        write_buckets(16'd0);
        key_bytes_pending.push_back(8'h00);
        push_key(5, 1'b1);
        push_random_keys(40);
        wait_idle();

        // leave a key unterminated across the next register write
        write_buckets(16'd1);
        push_random_keys(40);
        push_key(3, 1'b0);
        wait_idle();

        write_buckets(16'hffff);
        key_bytes_pending.push_back(8'h00);
        repeat (10) key_bytes_pending.push_back(8'hff);
        key_bytes_pending.push_back(8'h00);
        push_random_keys(50);
        wait_idle();

        calm = 1'b1;
        write_buckets(16'd7);
        push_random_keys(60);
        wait_idle();
        calm = 1'b0;

        write_buckets(16'd256);
        push_random_keys(50);
        push_key(6, 1'b0);
        wait_idle();

        write_buckets(BUCKET_W'($urandom_range(65535, 2)));
        push_random_keys(50);
        wait_idle();

        write_buckets(NUM_BUCKETS_RST);
        push_random_keys(50);
        wait_idle();

        mismatches += bucket_expect.size();
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
